/* rtl/core/interval_window_statistics_defines.svh */
// assertion macros for the interval window statistics checker
// expects signals named clock and reset in the scope of use
`ifndef INTERVAL_WINDOW_STATISTICS_DEFINES_SVH
`define INTERVAL_WINDOW_STATISTICS_DEFINES_SVH

// same-cycle implication, quiet during reset
`define IWS_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("iws check failed");

// next-cycle implication, quiet during reset
`define IWS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("iws check failed");

`endif

/* rtl/core/iws_pkg.sv */
// shared widths, codes, config and command types for interval window statistics
// no dependencies
`default_nettype none

package iws_pkg;

   localparam int TIME_W          = 63;
   localparam int VALUE_W         = 32;
   localparam int STAT_W          = 56;
   localparam int INTERVAL_W      = 40;
   localparam int MODE_W          = 4;
   localparam int CAP_W           = 48;
   localparam int CNT_W           = 32;
   localparam int SUM_W           = 64;
   localparam int EMIT_W          = 6;
   localparam int MAX_GAP_RECORDS = 62;
   localparam int HEADER_BYTES    = 38;
   localparam int DIV_NUM_W       = 80;
   localparam int DIV_DEN_W       = 64;
   localparam int DIV_CNT_W       = 7;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd2;

   localparam logic [MODE_W-1:0] MODE_COUNT    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SUM      = 4'd1;
   localparam logic [MODE_W-1:0] MODE_CAPACITY = 4'd2;
   localparam logic [MODE_W-1:0] MODE_AVG      = 4'd3;
   localparam logic [MODE_W-1:0] MODE_MIN      = 4'd4;
   localparam logic [MODE_W-1:0] MODE_MAX      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_RANGE    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_USE      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_FREE     = 4'd8;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 40'd1000000000;
   localparam logic [CAP_W-1:0]      CAPACITY_RESET = 48'd1000000;

   localparam logic [STAT_W-1:0] STAT_POS_MAX = {1'b0, {(STAT_W-1){1'b1}}};
   localparam logic [STAT_W-1:0] STAT_NEG_MIN = {1'b1, {(STAT_W-1){1'b0}}};

   typedef struct packed {
      logic [INTERVAL_W-1:0] interval;
      logic [MODE_W-1:0]     mode;
      logic [CAP_W-1:0]      capacity;
   } cfg_type;

   // one classified sample handed from front to back
   typedef struct packed {
      logic                      time_error;
      logic                      close_old;
      logic                      close_now;
      logic                      trunc;
      logic [EMIT_W-1:0]         emit;
      logic [TIME_W-1:0]         first_end;
      logic [TIME_W-1:0]         sample_time;
      logic signed [VALUE_W-1:0] sample_value;
   } cmd_type;

   function automatic logic [INTERVAL_W-1:0] eff_interval(input logic [INTERVAL_W-1:0] iv);
      eff_interval = (iv == '0) ? INTERVAL_W'(1) : iv;
   endfunction

   function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      eff_capacity = (cap == '0) ? CAP_W'(1) : cap;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/iws_channels.sv */
// valid/ready channel interfaces for sample words and result words
// depends on iws_pkg
`default_nettype none

interface iws_req_if import iws_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TIME_W-1:0]         sample_time;
   logic signed [VALUE_W-1:0] sample_value;
   modport source (output valid, sample_time, sample_value, input ready);
   modport sink (input valid, sample_time, sample_value, output ready);
endinterface

interface iws_rsp_if import iws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [TIME_W-1:0]        window_end_time;
   logic signed [STAT_W-1:0] stat_value;
   logic                     is_gap_fill;
   logic                     gap_truncated;
   logic                     time_error;
   logic                     last_of_run;
   modport source (output valid, window_end_time, stat_value, is_gap_fill, gap_truncated,
                   time_error, last_of_run, input ready);
   modport sink (input valid, window_end_time, stat_value, is_gap_fill, gap_truncated,
                 time_error, last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/iws_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on iws_pkg
`default_nettype none

module iws_divider import iws_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [DIV_NUM_W-1:0]  num,
   input  wire [DIV_DEN_W-1:0]  den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo,
   output logic [DIV_DEN_W-1:0] rem
);

   logic                 active_ff, done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_NUM_W-1:0] num_ff, quo_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   rem_ff;
   logic [DIV_DEN_W:0]   shifted, diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= active_ff && !start && (count_ff == DIV_CNT_W'(1));
         if (start) begin
            active_ff <= 1'b1;
            count_ff  <= DIV_CNT_W'(DIV_NUM_W);
            num_ff    <= num;
            den_ff    <= den;
            rem_ff    <= '0;
            quo_ff    <= '0;
         end else if (active_ff) begin
            num_ff   <= {num_ff[DIV_NUM_W-2:0], 1'b0};
            rem_ff   <= ge ? diff : shifted;
            quo_ff   <= {quo_ff[DIV_NUM_W-2:0], ge};
            count_ff <= count_ff - DIV_CNT_W'(1);
            if (count_ff == DIV_CNT_W'(1)) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff[DIV_DEN_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/iws_front.sv */
// front end: accepts samples, tracks the window start, classifies each sample
// depends on iws_pkg, iws_channels, iws_divider
`default_nettype none

module iws_front import iws_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  cfg_type  cfg,
   iws_req_if.sink  req,
   output cmd_type  cmd,
   output logic     push,
   input  wire      full
);

   typedef enum logic [2:0] {F_IDLE, F_CLASSIFY, F_DIVIDE, F_CHECK, F_PUSH} front_state_type;

   front_state_type           state_ff;
   logic [TIME_W-1:0]         time_ff, ws_ff, wsn_ff;
   logic signed [VALUE_W-1:0] value_ff;
   cmd_type                   cmd_ff;

   logic [INTERVAL_W-1:0] iv;
   logic                  div_start, div_done;
   logic [DIV_NUM_W-1:0]  div_quo;
   logic [DIV_DEN_W-1:0]  div_rem;
   logic [TIME_W:0]       dm1, ws_end, wsn_end;
   logic                  div_trunc;

   always_comb begin
      iv        = eff_interval(cfg.interval);
      dm1       = {1'b0, time_ff} - {1'b0, ws_ff} - (TIME_W+1)'(1);
      ws_end    = {1'b0, ws_ff} + (TIME_W+1)'(iv);
      wsn_end   = {1'b0, wsn_ff} + (TIME_W+1)'(iv);
      div_start = (state_ff == F_CLASSIFY) && (time_ff > ws_ff);
      div_trunc = div_quo > DIV_NUM_W'(MAX_GAP_RECORDS + 1);
   end

   iws_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (DIV_NUM_W'(dm1)),
      .den   (DIV_DEN_W'(iv)),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         ws_ff    <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req.valid) begin
                  time_ff  <= req.sample_time;
                  value_ff <= req.sample_value;
                  state_ff <= F_CLASSIFY;
               end
            end
            F_CLASSIFY: begin
               cmd_ff.first_end    <= ws_end[TIME_W-1:0];
               cmd_ff.sample_time  <= time_ff;
               cmd_ff.sample_value <= value_ff;
               cmd_ff.close_old    <= 1'b0;
               cmd_ff.close_now    <= 1'b0;
               cmd_ff.trunc        <= 1'b0;
               cmd_ff.emit         <= '0;
               cmd_ff.time_error   <= time_ff < ws_ff;
               wsn_ff              <= ws_ff;
               if (time_ff < ws_ff) begin
                  state_ff <= F_PUSH;
               end else if (time_ff == ws_ff) begin
                  state_ff <= F_CHECK;
               end else begin
                  state_ff <= F_DIVIDE;
               end
            end
            F_DIVIDE: begin
               if (div_done) begin
                  if (div_quo != '0) begin
                     cmd_ff.close_old <= 1'b1;
                     cmd_ff.trunc     <= div_trunc;
                     cmd_ff.emit      <= div_trunc ? EMIT_W'(MAX_GAP_RECORDS)
                                                   : EMIT_W'(div_quo[EMIT_W-1:0] - EMIT_W'(1));
                     wsn_ff <= time_ff - TIME_W'(1) - TIME_W'(div_rem[INTERVAL_W-1:0]);
                  end
                  state_ff <= F_CHECK;
               end
            end
            F_CHECK: begin
               // sample right on the window end closes that window
               cmd_ff.close_now <= wsn_end == {1'b0, time_ff};
               ws_ff            <= (wsn_end == {1'b0, time_ff}) ? time_ff : wsn_ff;
               state_ff         <= F_PUSH;
            end
            F_PUSH: begin
               if (!full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_PUSH) && !full;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

/* rtl/core/iws_cmd_queue.sv */
// two-entry queue of classified samples between front and back
// depends on iws_pkg
`default_nettype none

module iws_cmd_queue import iws_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     push,
   input  cmd_type push_cmd,
   input  wire     pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign full  = fill_ff == 2'd2;
   assign empty = fill_ff == 2'd0;

endmodule

`default_nettype wire

/* rtl/core/iws_back.sv */
// back end: window accumulators, statistic unit and result register
// depends on iws_pkg, iws_channels, iws_divider
`default_nettype none

module iws_back import iws_pkg::*; (
   input  wire       clock,
   input  wire       reset,
   input  cfg_type   cfg,
   input  cmd_type   head,
   input  wire       empty,
   output logic      pop,
   iws_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      B_IDLE, B_ERR_OUT, B_STAT_A, B_STAT_B, B_STAT_C, B_STAT_WAIT, B_STAT_FIX,
      B_OLD_OUT, B_GAP_OUT, B_ADD, B_NOW_OUT
   } back_state_type;

   back_state_type            state_ff;
   cmd_type                   cmd_ff;
   logic                      phase_now_ff;
   logic [CNT_W-1:0]          count_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [VALUE_W-1:0] min_ff, max_ff;
   logic                      sneg_ff, neg_ff;
   logic [SUM_W-1:0]          smag_ff;
   logic [CNT_W+5:0]          hdr_ff;
   logic [DIV_NUM_W-1:0]      part_ff, num_ff;
   logic [DIV_DEN_W-1:0]      den_ff;
   logic [STAT_W-1:0]         stat_ff;
   logic [TIME_W-1:0]         gap_end_ff;
   logic [EMIT_W-1:0]         idx_ff;

   logic                     rsp_valid_ff, rsp_gap_ff, rsp_trunc_ff, rsp_err_ff, rsp_last_ff;
   logic [TIME_W-1:0]        rsp_end_ff;
   logic [STAT_W-1:0]        rsp_stat_ff;

   logic [INTERVAL_W-1:0] iv;
   logic                  out_free;
   logic                  word_load;
   logic [SUM_W-1:0]      smag;
   logic [STAT_W-1:0]     direct_stat;
   logic                  need_div;
   logic [VALUE_W:0]      span;
   logic [SUM_W-1:0]      dmag;
   logic                  dneg;
   logic                  div_start, div_done;
   logic [DIV_NUM_W-1:0]  div_quo;
   logic [DIV_DEN_W-1:0]  div_rem;
   logic [DIV_NUM_W:0]    qr;
   logic [STAT_W-1:0]     ratio_stat;
   logic signed [STAT_W+1:0] free_val;
   logic signed [SUM_W-1:0]  sum_add, vext;
   logic                  sum_ovf, last_gap;
   back_state_type        stat_done_state;

   always_comb begin
      iv        = eff_interval(cfg.interval);
      out_free  = !rsp_valid_ff || rsp.ready;
      word_load = out_free && ((state_ff == B_ERR_OUT) || (state_ff == B_OLD_OUT) ||
                               (state_ff == B_GAP_OUT) || (state_ff == B_NOW_OUT));
      smag     = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
      span     = {max_ff[VALUE_W-1], max_ff} - {min_ff[VALUE_W-1], min_ff};
      stat_done_state = phase_now_ff ? B_NOW_OUT : B_OLD_OUT;

      // statistics that need no divide
      direct_stat = '0;
      need_div    = 1'b0;
      if (count_ff != '0) begin
         unique case (cfg.mode)
            MODE_COUNT: direct_stat = STAT_W'({count_ff, 8'b0});
            MODE_SUM: begin
               if (!sum_ff[SUM_W-1] && (sum_ff[SUM_W-2:47] != '0)) begin
                  direct_stat = STAT_POS_MAX;
               end else if (sum_ff[SUM_W-1] && !(&sum_ff[SUM_W-2:47])) begin
                  direct_stat = STAT_NEG_MIN;
               end else begin
                  direct_stat = {sum_ff[47:0], 8'b0};
               end
            end
            MODE_MIN:   direct_stat = {{16{min_ff[VALUE_W-1]}}, min_ff, 8'b0};
            MODE_MAX:   direct_stat = {{16{max_ff[VALUE_W-1]}}, max_ff, 8'b0};
            MODE_RANGE: direct_stat = {{15{span[VALUE_W]}}, span, 8'b0};
            MODE_CAPACITY, MODE_AVG, MODE_USE, MODE_FREE: need_div = 1'b1;
            default: direct_stat = '0;
         endcase
      end

      // header-overhead denominator
      if (!sneg_ff) begin
         dmag = smag_ff + SUM_W'(hdr_ff);
         dneg = 1'b0;
      end else if (smag_ff > SUM_W'(hdr_ff)) begin
         dmag = smag_ff - SUM_W'(hdr_ff);
         dneg = 1'b1;
      end else begin
         dmag = SUM_W'(hdr_ff) - smag_ff;
         dneg = 1'b0;
      end

      // round half away from zero, then saturate
      qr = {1'b0, div_quo} + (DIV_NUM_W+1)'(div_rem >= (den_ff - div_rem));
      if (!neg_ff) begin
         ratio_stat = (qr > (DIV_NUM_W+1)'(STAT_POS_MAX)) ? STAT_POS_MAX : qr[STAT_W-1:0];
      end else begin
         ratio_stat = (qr > (DIV_NUM_W+1)'(STAT_NEG_MIN)) ? STAT_NEG_MIN
                                                          : STAT_W'(0) - qr[STAT_W-1:0];
      end
      free_val = (STAT_W+2)'(25600) - {{2{stat_ff[STAT_W-1]}}, stat_ff};

      vext    = SUM_W'(signed'(cmd_ff.sample_value));
      sum_add = sum_ff + vext;
      sum_ovf = (vext[SUM_W-1] == sum_ff[SUM_W-1]) && (sum_add[SUM_W-1] != sum_ff[SUM_W-1]);

      last_gap  = (idx_ff == cmd_ff.emit - EMIT_W'(1)) && !cmd_ff.close_now;
      div_start = state_ff == B_STAT_C;
      pop       = (state_ff == B_IDLE) && !empty;
   end

   iws_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= {1'b0, {(VALUE_W-1){1'b1}}};
         max_ff       <= {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         if (rsp.ready && !word_load) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  cmd_ff       <= head;
                  phase_now_ff <= 1'b0;
                  if (head.time_error)     state_ff <= B_ERR_OUT;
                  else if (head.close_old) state_ff <= B_STAT_A;
                  else                     state_ff <= B_ADD;
               end
            end
            B_ERR_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_end_ff   <= cmd_ff.first_end;
                  rsp_stat_ff  <= '0;
                  rsp_gap_ff   <= 1'b0;
                  rsp_trunc_ff <= 1'b0;
                  rsp_err_ff   <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            B_STAT_A: begin
               sneg_ff <= sum_ff[SUM_W-1];
               smag_ff <= smag;
               hdr_ff  <= (CNT_W+6)'(count_ff) * (CNT_W+6)'(HEADER_BYTES);
               part_ff <= (cfg.mode == MODE_AVG) ? (DIV_NUM_W'(smag) << 8)
                        : (DIV_NUM_W'(smag) << 14) + (DIV_NUM_W'(smag) << 13);
               stat_ff <= direct_stat;
               state_ff <= need_div ? B_STAT_B : stat_done_state;
            end
            B_STAT_B: begin
               // 25600 = 2^14 + 2^13 + 2^10
               num_ff <= (cfg.mode == MODE_AVG) ? part_ff
                                                : part_ff + (DIV_NUM_W'(smag_ff) << 10);
               priority if (cfg.mode == MODE_AVG) begin
                  den_ff   <= DIV_DEN_W'(count_ff);
                  neg_ff   <= sneg_ff;
                  state_ff <= B_STAT_C;
               end else if (cfg.mode == MODE_CAPACITY) begin
                  den_ff <= dmag;
                  neg_ff <= sneg_ff ^ dneg;
                  if (dmag == '0) begin
                     stat_ff  <= '0;
                     state_ff <= stat_done_state;
                  end else begin
                     state_ff <= B_STAT_C;
                  end
               end else begin
                  den_ff   <= DIV_DEN_W'(eff_capacity(cfg.capacity));
                  neg_ff   <= sneg_ff;
                  state_ff <= B_STAT_C;
               end
            end
            B_STAT_C: state_ff <= B_STAT_WAIT;
            B_STAT_WAIT: begin
               if (div_done) begin
                  stat_ff  <= ratio_stat;
                  state_ff <= B_STAT_FIX;
               end
            end
            B_STAT_FIX: begin
               if (cfg.mode == MODE_FREE) begin
                  stat_ff <= (free_val > $signed({2'b0, STAT_POS_MAX})) ? STAT_POS_MAX
                                                                        : free_val[STAT_W-1:0];
               end
               state_ff <= stat_done_state;
            end
            B_OLD_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_end_ff   <= cmd_ff.first_end;
                  rsp_stat_ff  <= stat_ff;
                  rsp_gap_ff   <= 1'b0;
                  rsp_err_ff   <= 1'b0;
                  rsp_last_ff  <= (cmd_ff.emit == '0) && !cmd_ff.close_now;
                  rsp_trunc_ff <= (cmd_ff.emit == '0) && !cmd_ff.close_now && cmd_ff.trunc;
                  count_ff     <= '0;
                  sum_ff       <= '0;
                  min_ff       <= {1'b0, {(VALUE_W-1){1'b1}}};
                  max_ff       <= {1'b1, {(VALUE_W-1){1'b0}}};
                  gap_end_ff   <= cmd_ff.first_end;
                  idx_ff       <= '0;
                  state_ff     <= (cmd_ff.emit == '0) ? B_ADD : B_GAP_OUT;
               end
            end
            B_GAP_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_end_ff   <= TIME_W'({1'b0, gap_end_ff} + (TIME_W+1)'(iv));
                  gap_end_ff   <= TIME_W'({1'b0, gap_end_ff} + (TIME_W+1)'(iv));
                  rsp_stat_ff  <= '0;
                  rsp_gap_ff   <= 1'b1;
                  rsp_err_ff   <= 1'b0;
                  rsp_last_ff  <= last_gap;
                  rsp_trunc_ff <= last_gap && cmd_ff.trunc;
                  idx_ff       <= idx_ff + EMIT_W'(1);
                  if (idx_ff == cmd_ff.emit - EMIT_W'(1)) state_ff <= B_ADD;
               end
            end
            B_ADD: begin
               sum_ff <= sum_ovf ? (vext[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                  : {1'b0, {(SUM_W-1){1'b1}}})
                                 : sum_add;
               if (count_ff != '1) count_ff <= count_ff + CNT_W'(1);
               if (cmd_ff.sample_value < min_ff) min_ff <= cmd_ff.sample_value;
               if (cmd_ff.sample_value > max_ff) max_ff <= cmd_ff.sample_value;
               phase_now_ff <= 1'b1;
               state_ff     <= cmd_ff.close_now ? B_STAT_A : B_IDLE;
            end
            B_NOW_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_end_ff   <= cmd_ff.sample_time;
                  rsp_stat_ff  <= stat_ff;
                  rsp_gap_ff   <= 1'b0;
                  rsp_err_ff   <= 1'b0;
                  rsp_last_ff  <= 1'b1;
                  rsp_trunc_ff <= cmd_ff.trunc;
                  count_ff     <= '0;
                  sum_ff       <= '0;
                  min_ff       <= {1'b0, {(VALUE_W-1){1'b1}}};
                  max_ff       <= {1'b1, {(VALUE_W-1){1'b0}}};
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.window_end_time = rsp_end_ff;
   assign rsp.stat_value      = rsp_stat_ff;
   assign rsp.is_gap_fill     = rsp_gap_ff;
   assign rsp.gap_truncated   = rsp_trunc_ff;
   assign rsp.time_error      = rsp_err_ff;
   assign rsp.last_of_run     = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/core/interval_window_statistics.sv */
// top level of the interval window statistics block: config registers, front, queue, back
// depends on iws_pkg, iws_channels, iws_front, iws_cmd_queue, iws_back
//
// usage
//   req_chan carries one sample word (sample_time, sample_value) per valid/ready handshake
//   rsp_chan carries result words: a closed window's statistic, zero words for empty
//   windows (at most 62 per sample), or one time_error word for a backwards timestamp;
//   last_of_run marks the final word a sample caused, and some samples cause none
//   csr_* writes interval_ticks, stat_mode, window_capacity by index; the user must write
//   only while idle, which the block itself leaves unchecked
// flow
//   the front takes a sample, then classifies, checks and pushes it, with an 80-step
//   radix-2 divide of the elapsed time when the sample lies past the window start; the
//   back adds each sample to the window; a statistic is direct, or runs the divide in the
//   divide-based modes (capacity, average, use, free) unless the capacity denominator
//   is zero; each word then waits for a free output register; front and back run apart
//   through a two-entry queue, so a new sample is taken while the back is still emitting
// reset
//   synchronous, clears window state and loads the register defaults
// stall
//   results sit in an output register; while rsp_chan.ready is low the back holds,
//   the queue fills, and then req_chan.ready drops
`default_nettype none

module interval_window_statistics import iws_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   iws_req_if.sink                req_chan,
   iws_rsp_if.source              rsp_chan,
   input  wire                    csr_write_enable,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_write_data
);

   cfg_type cfg_ff;
   cmd_type front_cmd, queue_head;
   logic    queue_push, queue_pop, queue_full, queue_empty;

   // register file, unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval <= INTERVAL_RESET;
         cfg_ff.mode     <= MODE_COUNT;
         cfg_ff.capacity <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INTERVAL: cfg_ff.interval <= csr_write_data[INTERVAL_W-1:0];
            CSR_MODE:     cfg_ff.mode     <= csr_write_data[MODE_W-1:0];
            CSR_CAPACITY: cfg_ff.capacity <= csr_write_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // classify samples and advance the window start
   iws_front u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_chan),
      .cmd   (front_cmd),
      .push  (queue_push),
      .full  (queue_full)
   );

   iws_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (front_cmd),
      .pop      (queue_pop),
      .head     (queue_head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // accumulate, compute statistics and emit result words
   iws_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (queue_head),
      .empty (queue_empty),
      .pop   (queue_pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

/* rtl/core/iws_checker.sv */
// port-level checks for interval window statistics, bound to the top level
// depends on iws_pkg and interval_window_statistics_defines.svh
`default_nettype none
`include "interval_window_statistics_defines.svh"

module iws_checker import iws_pkg::*; (
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire [TIME_W-1:0]        rsp_window_end_time,
   input wire signed [STAT_W-1:0] rsp_stat_value,
   input wire                     rsp_is_gap_fill,
   input wire                     rsp_gap_truncated,
   input wire                     rsp_time_error,
   input wire                     rsp_last_of_run
);

   // a stalled word holds
   `IWS_ASSERT_NEXT(rsp_hold_chk, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_window_end_time) && $stable(rsp_stat_value))

   // error words stand alone and carry nothing else
   `IWS_ASSERT_NOW(err_word_chk, rsp_valid && rsp_time_error, rsp_last_of_run && rsp_stat_value == '0 && !rsp_is_gap_fill && !rsp_gap_truncated)

   // gap words are zero
   `IWS_ASSERT_NOW(gap_zero_chk, rsp_valid && rsp_is_gap_fill, rsp_stat_value == '0 && !rsp_time_error)

   // truncation flag only on the final word of a run
   `IWS_ASSERT_NOW(trunc_last_chk, rsp_valid && rsp_gap_truncated, rsp_last_of_run)

endmodule

bind interval_window_statistics iws_checker u_iws_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_window_end_time (rsp_chan.window_end_time),
   .rsp_stat_value      (rsp_chan.stat_value),
   .rsp_is_gap_fill     (rsp_chan.is_gap_fill),
   .rsp_gap_truncated   (rsp_chan.gap_truncated),
   .rsp_time_error      (rsp_chan.time_error),
   .rsp_last_of_run     (rsp_chan.last_of_run)
);

`default_nettype wire
